/* design/burner_ignition_sequencer_unit_defines.svh */
// Assertion macros shared by the burner ignition sequencer RTL.
`ifndef BURNER_IGNITION_SEQUENCER_UNIT_DEFINES_SVH
`define BURNER_IGNITION_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BIS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BIS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bis_pkg.sv */
// Types, codes and helpers of the burner ignition sequencer.
package bis_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_IGN_WAIT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BLINK_IGN  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BLINK_LOCK = 2'd2;

  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgDataW-1:0] IGN_WAIT_RST   = 8'd8;
  localparam logic [CfgDataW-1:0] BLINK_IGN_RST  = 8'd2;
  localparam logic [CfgDataW-1:0] BLINK_LOCK_RST = 8'd1;

  // Mode codes as seen on the result item
  localparam logic [1:0] MODE_CODE_WAIT     = 2'd0;
  localparam logic [1:0] MODE_CODE_IGNITION = 2'd1;
  localparam logic [1:0] MODE_CODE_WORKING  = 2'd2;
  localparam logic [1:0] MODE_CODE_LOCKOUT  = 2'd3;

  typedef enum logic [3:0] {
    ModeWait     = 4'b0001,
    ModeIgnition = 4'b0010,
    ModeWorking  = 4'b0100,
    ModeLockout  = 4'b1000
  } mode_e;

  typedef enum logic [2:0] {
    PhSetup  = 3'b001,
    PhFirst  = 3'b010,
    PhSecond = 3'b100
  } phase_e;

  typedef struct packed {
    logic tick;
    logic start_request;
    logic fuel_ok;
    logic oil_warm;
    logic flame_seen;
  } in_item_t;

  typedef struct packed {
    logic       air_on;
    logic       spark_on;
    logic       led_on;
    logic       lockout;
    logic [1:0] mode;
  } out_item_t;

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] c;
    unique case (m)
      ModeWait:     c = MODE_CODE_WAIT;
      ModeIgnition: c = MODE_CODE_IGNITION;
      ModeWorking:  c = MODE_CODE_WORKING;
      ModeLockout:  c = MODE_CODE_LOCKOUT;
      default:      c = MODE_CODE_WAIT;
    endcase
    return c;
  endfunction

endpackage

/* design/bis_if.sv */
// Valid/ready channels carrying control-loop items and result items.
interface bis_in_if;
  logic               valid;
  logic               ready;
  bis_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bis_out_if;
  logic               valid;
  logic               ready;
  bis_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/burner_ignition_sequencer_unit.sv */
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while the result register can drain; the sequencer state
// updates as an item leaves the input register, through one level of mode/phase logic and
// two 8-bit decrementers. Reset: asynchronous, active low; mode wait, timers and drives
// cleared, registers back to wait 8, ignition blink 2, lockout blink 1.
module burner_ignition_sequencer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bis_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [bis_pkg::CfgDataW-1:0]    cfg_data_i,
  bis_in_if.sink                          in_i,
  bis_out_if.source                       out_o
);
  import bis_pkg::*;
  `include "burner_ignition_sequencer_unit_defines.svh"

  logic [CfgDataW-1:0] ign_wait_q, blink_ign_q, blink_lock_q;

  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      adv;

  mode_e       mode_q, mode_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  ign_timer_q, ign_timer_d, it_dec;
  logic [7:0]  blink_timer_q, blink_timer_d, bt_dec;
  logic        preset_q, preset_d;
  logic        air_q, air_d, spark_q, spark_d, led_q, led_d;

  logic        out_valid_q;
  out_item_t   out_item_q, out_item_d;

  // Handshake: advance when the result register is free or being drained
  assign adv         = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || adv;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ign_wait_q   <= IGN_WAIT_RST;
      blink_ign_q  <= BLINK_IGN_RST;
      blink_lock_q <= BLINK_LOCK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IGN_WAIT:   ign_wait_q   <= cfg_data_i;
        CFG_BLINK_IGN:  blink_ign_q  <= cfg_data_i;
        CFG_BLINK_LOCK: blink_lock_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q <= in_i.data;
    end
  end

  // Sequencer next state for the item in the input register
  always_comb begin
    it_dec = ign_timer_q;
    bt_dec = blink_timer_q;
    if (s1_item_q.tick && (ign_timer_q != 8'd0)) it_dec = ign_timer_q - 8'd1;
    if (s1_item_q.tick && (blink_timer_q != 8'd0)) bt_dec = blink_timer_q - 8'd1;

    // latch warm status while fuel is present, outside lockout
    preset_d = preset_q;
    if ((mode_q != ModeLockout) && s1_item_q.fuel_ok) preset_d = s1_item_q.oil_warm;

    // blinker
    blink_timer_d = bt_dec;
    led_d         = led_q;
    if (bt_dec == 8'd0) begin
      unique case (mode_q)
        ModeWait:     led_d = 1'b0;
        ModeIgnition: begin
          blink_timer_d = blink_ign_q;
          led_d         = !led_q;
        end
        ModeWorking:  led_d = 1'b1;
        ModeLockout:  begin
          blink_timer_d = blink_lock_q;
          led_d         = !led_q;
        end
        default: ;
      endcase
    end

    mode_d      = mode_q;
    phase_d     = phase_q;
    ign_timer_d = it_dec;
    air_d       = air_q;
    spark_d     = spark_q;

    unique case (mode_q)
      ModeWait: begin
        air_d   = 1'b0;
        spark_d = 1'b0;
        led_d   = 1'b0;
        if (s1_item_q.start_request && preset_d) begin
          mode_d  = ModeIgnition;
          phase_d = PhSetup;
        end
      end
      ModeIgnition: begin
        if (!s1_item_q.start_request) begin
          mode_d = ModeWait;
        end else begin
          unique case (phase_q)
            PhSetup: begin
              air_d       = 1'b1;
              spark_d     = 1'b1;
              ign_timer_d = ign_wait_q;
              phase_d     = PhFirst;
            end
            PhFirst, PhSecond: begin
              // sample flame once the spark period has run out
              if (it_dec == 8'd0) begin
                spark_d = 1'b0;
                if (s1_item_q.flame_seen) begin
                  mode_d  = ModeWorking;
                  phase_d = PhSetup;
                end else if (phase_q == PhFirst) begin
                  phase_d     = PhSecond;
                  spark_d     = 1'b1;
                  ign_timer_d = ign_wait_q;
                end else begin
                  phase_d = PhSetup;
                  mode_d  = ModeLockout;
                end
              end
            end
            default: phase_d = PhSetup;
          endcase
        end
      end
      ModeWorking: begin
        // lost flame wins over start withdrawn
        if (!s1_item_q.flame_seen) begin
          mode_d = ModeIgnition;
        end else if (!s1_item_q.start_request) begin
          mode_d = ModeWait;
        end
        spark_d = 1'b0;
      end
      ModeLockout: begin
        air_d   = 1'b0;
        spark_d = 1'b0;
      end
      default: mode_d = ModeWait;
    endcase

    out_item_d.air_on   = air_d;
    out_item_d.spark_on = spark_d;
    out_item_d.led_on   = led_d;
    out_item_d.lockout  = (mode_d == ModeLockout);
    out_item_d.mode     = mode_code(mode_d);
  end

  // Sequencer state, updated as each item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= ModeWait;
      phase_q       <= PhSetup;
      ign_timer_q   <= 8'd0;
      blink_timer_q <= 8'd0;
      preset_q      <= 1'b0;
      air_q         <= 1'b0;
      spark_q       <= 1'b0;
      led_q         <= 1'b0;
    end else if (adv) begin
      mode_q        <= mode_d;
      phase_q       <= phase_d;
      ign_timer_q   <= ign_timer_d;
      blink_timer_q <= blink_timer_d;
      preset_q      <= preset_d;
      air_q         <= air_d;
      spark_q       <= spark_d;
      led_q         <= led_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q <= out_item_d;
    end
  end

  // Lockout is left only by reset
  `BIS_ASSERT_NXT(a_lockout_sticky, mode_q == ModeLockout, mode_q == ModeLockout, "lockout left")
  // Spark can only stay on in ignition, or for one pass after start is withdrawn
  `BIS_ASSERT_IMP(a_spark_mode, spark_q,
                  (mode_q == ModeIgnition) || (mode_q == ModeWait), "spark on outside ignition")
  // Sequencer state holds while no item advances
  `BIS_ASSERT_NXT(a_state_hold, !adv,
                  $stable(mode_q) && $stable(ign_timer_q) && $stable(led_q), "state moved")

endmodule
